/* sv/nrsc_pkg.sv */
// shared types, codes and constants of the news-reply stream classifier
`timescale 1ns / 1ps

package nrsc_pkg;

  // one input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       from_server;
    logic       last_in_segment;
    logic       new_flow;
  } in_t;

  // one result request
  typedef struct packed {
    logic [1:0] verdict;
    logic [9:0] reply_code;
  } out_t;

  typedef enum logic [5:0] {
    PhConn   = 6'b000001,
    PhXfer   = 6'b000010,
    PhData   = 6'b000100,
    PhErr    = 6'b001000,
    PhIdent  = 6'b010000,
    PhReject = 6'b100000
  } flow_phase_e;

  typedef enum logic [5:0] {
    LpSkip = 6'b000001,
    LpHdr1 = 6'b000010,
    LpHdr2 = 6'b000100,
    LpHdr3 = 6'b001000,
    LpText = 6'b010000,
    LpCr   = 6'b100000
  } line_phase_e;

  typedef struct packed {
    logic term;  // dot seen at line start
    logic mid;   // inside a line
    logic cr;    // cr seen
  } body_flags_t;

  typedef struct packed {
    flow_phase_e flow_phase;
    body_flags_t body_flags;
    logic [3:0]  reply_count;
    line_phase_e line_phase;
    logic [9:0]  code_accum;
    logic        hdr_all_space;
    logic        hdr_bad;
    logic [9:0]  last_code;
  } state_t;

  localparam state_t StateClear = '{
    flow_phase:    PhConn,
    body_flags:    '0,
    reply_count:   4'd0,
    line_phase:    LpSkip,
    code_accum:    10'd0,
    hdr_all_space: 1'b1,
    hdr_bad:       1'b0,
    last_code:     10'd0
  };

  localparam logic [1:0] VerdictPending  = 2'd0;
  localparam logic [1:0] VerdictIdent    = 2'd1;
  localparam logic [1:0] VerdictRejected = 2'd2;

  localparam logic [3:0] ThreshReset = 4'd4;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam logic [9:0] CodeReady     = 10'd200;
  localparam logic [9:0] CodeReadyRo   = 10'd201;
  localparam logic [9:0] CodeErrDown   = 10'd400;
  localparam logic [9:0] CodeErrDenied = 10'd502;
  localparam logic [9:0] CodeHelp      = 10'd100;
  localparam logic [9:0] CodeList      = 10'd215;
  localparam logic [9:0] CodeArticle   = 10'd220;
  localparam logic [9:0] CodeHead      = 10'd221;
  localparam logic [9:0] CodeBody      = 10'd222;
  localparam logic [9:0] CodeOverview  = 10'd224;
  localparam logic [9:0] CodeNewNews   = 10'd230;
  localparam logic [9:0] CodeNewGroups = 10'd231;

endpackage

/* sv/nrsc_step.sv */
// next-state and result logic for one byte of the classifier
`timescale 1ns / 1ps

module nrsc_step (
  input  nrsc_pkg::state_t state_i,
  input  nrsc_pkg::in_t    item_i,
  input  logic [3:0]       thresh_i,
  output nrsc_pkg::state_t state_o,
  output logic             res_vld_o,
  output nrsc_pkg::out_t   res_o
);
  import nrsc_pkg::*;

  function automatic state_t line_restart(state_t s);
    state_t r;
    r = s;
    r.line_phase    = LpSkip;
    r.code_accum    = 10'd0;
    r.hdr_all_space = 1'b1;
    r.hdr_bad       = 1'b0;
    return r;
  endfunction

  function automatic state_t finish_code(state_t s, logic [3:0] thr);
    state_t     r;
    logic [9:0] c;
    logic [3:0] cnt;
    c = s.code_accum;
    r = line_restart(s);
    r.last_code = c;
    cnt = s.reply_count + 4'd1;
    if (c == CodeErrDown || c == CodeErrDenied) begin
      r.flow_phase = PhErr;
    end else begin
      case (s.flow_phase)
        PhConn: begin
          r.flow_phase = (c == CodeReady || c == CodeReadyRo) ? PhXfer : PhReject;
        end
        PhXfer: begin
          r.reply_count = cnt;
          if (cnt >= thr) begin
            r.flow_phase = PhIdent;
          end else if (c inside {CodeHelp, CodeList, CodeArticle, CodeHead, CodeBody,
                                 CodeOverview, CodeNewNews, CodeNewGroups}) begin
            r.flow_phase = PhData;
            r.body_flags = '0;
          end
        end
        default: begin
          r.flow_phase = PhReject;
        end
      endcase
    end
    return r;
  endfunction

  function automatic state_t hdr_byte(state_t s, logic [1:0] pos, logic [7:0] b,
                                      logic last);
    state_t     r;
    logic       ok;
    logic [9:0] add;
    logic [9:0] dig;
    r   = s;
    dig = {6'd0, b[3:0]};
    ok  = 1'b0;
    add = 10'd0;
    case (pos)
      2'd0: begin
        ok  = b inside {[8'h31:8'h35]};
        add = dig * 10'd100;
      end
      2'd1: begin
        ok  = b inside {[8'h30:8'h35], 8'h38, 8'h39};
        add = dig * 10'd10;
      end
      2'd2: begin
        ok  = b inside {[8'h30:8'h39]};
        add = dig;
      end
      default: begin
        ok  = (b == ChSpace);
        add = 10'd0;
      end
    endcase
    if (!(b == ChSpace || b inside {[8'h09:8'h0D]})) r.hdr_all_space = 1'b0;
    if (!ok) r.hdr_bad = 1'b1;
    else     r.code_accum = s.code_accum + add;
    if (pos == 2'd3) begin
      if (r.hdr_bad) r.flow_phase = PhReject;
      else           r.line_phase = LpText;
    end else begin
      case (pos)
        2'd0:    r.line_phase = LpHdr1;
        2'd1:    r.line_phase = LpHdr2;
        default: r.line_phase = LpHdr3;
      endcase
      // segment ended inside a header that is not just white space
      if (last && !r.hdr_all_space) r.flow_phase = PhReject;
    end
    return r;
  endfunction

  function automatic state_t reply_byte(state_t s, logic [7:0] b, logic last,
                                        logic [3:0] thr);
    state_t r;
    r = s;
    case (s.line_phase)
      LpSkip: begin
        if (b != ChCr && b != ChLf) r = hdr_byte(s, 2'd0, b, last);
      end
      LpHdr1: r = hdr_byte(s, 2'd1, b, last);
      LpHdr2: r = hdr_byte(s, 2'd2, b, last);
      LpHdr3: r = hdr_byte(s, 2'd3, b, last);
      LpText: begin
        if (b == ChCr) begin
          if (last) r.flow_phase = PhReject;
          else      r.line_phase = LpCr;
        end else if (b == ChLf) begin
          r = finish_code(s, thr);
        end else if (!(b inside {[8'h20:8'h7E]})) begin
          r.flow_phase = PhReject;
        end
      end
      LpCr: begin
        if (b == ChLf) r = finish_code(s, thr);
        else           r.flow_phase = PhReject;
      end
      default: r = line_restart(s);
    endcase
    return r;
  endfunction

  function automatic state_t body_end(state_t s);
    state_t r;
    r = line_restart(s);
    r.body_flags = '0;
    r.flow_phase = PhXfer;
    return r;
  endfunction

  function automatic state_t data_step(state_t s, logic [7:0] b);
    state_t      r;
    body_flags_t f;
    r = s;
    f = s.body_flags;
    if (f.cr) begin
      if (b != ChLf)  r.flow_phase = PhReject;
      else if (f.term) r = body_end(s);
      else             r.body_flags = '0;
    end else if (f.term) begin
      // dot at line start: terminator, stuffed dot or a bad line
      if (b == ChCr)       r.body_flags = '{term: 1'b1, mid: 1'b0, cr: 1'b1};
      else if (b == ChLf)  r = body_end(s);
      else if (b == ChDot) r.body_flags = '{term: 1'b0, mid: 1'b1, cr: 1'b0};
      else                 r.flow_phase = PhReject;
    end else if (!f.mid && b == ChDot) begin
      r.body_flags = '{term: 1'b1, mid: 1'b0, cr: 1'b0};
    end else if (b == ChCr) begin
      r.body_flags = '{term: 1'b0, mid: 1'b1, cr: 1'b1};
    end else if (b == ChLf) begin
      r.body_flags = '0;
    end else begin
      r.body_flags = '{term: 1'b0, mid: 1'b1, cr: 1'b0};
    end
    return r;
  endfunction

  state_t base;
  state_t nxt;

  always_comb begin
    base = item_i.new_flow ? StateClear : state_i;
    nxt  = base;
    res_vld_o = 1'b0;
    if (item_i.from_server) begin
      case (base.flow_phase)
        PhData:           nxt = data_step(base, item_i.data_byte);
        PhIdent, PhReject: nxt = base;
        default: begin
          nxt = reply_byte(base, item_i.data_byte, item_i.last_in_segment, thresh_i);
        end
      endcase
      if (item_i.last_in_segment) begin
        nxt = line_restart(nxt);
        res_vld_o = 1'b1;
      end
    end
  end

  assign state_o = nxt;

  always_comb begin
    case (nxt.flow_phase)
      PhIdent:  res_o.verdict = VerdictIdent;
      PhReject: res_o.verdict = VerdictRejected;
      default:  res_o.verdict = VerdictPending;
    endcase
    res_o.reply_code = nxt.last_code;
  end

endmodule

/* sv/nntp_reply_stream_classifier_core.sv */
// top level of the news-reply stream classifier: input register, flow state, result register
`timescale 1ns / 1ps
// path: input register, then flow state and result register once the byte fires
// throughput: one byte per cycle while the input does not stall, set by the flow state register
// input stalls only when a segment-end byte waits on a full result register, out_ready_i low
// reset: flow state cleared to connection phase, no pending request, threshold back to 4
// the user must write configuration over the apb port only while no byte is in flight; not enforced

module nntp_reply_stream_classifier_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  nrsc_pkg::in_t   in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output nrsc_pkg::out_t  out_item_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import nrsc_pkg::*;

  localparam logic [2:0] AddrConfirmThreshold = 3'h0;

  in_t        in_q;
  logic       in_vld_q;
  state_t     state_q;
  state_t     state_d;
  out_t       out_q;
  logic       out_vld_q;
  logic       out_vld_d;
  logic [3:0] thresh_q;
  logic       res_vld;
  out_t       res;
  logic       fire;

  nrsc_step u_step (
    .state_i   (state_q),
    .item_i    (in_q),
    .thresh_i  (thresh_q),
    .state_o   (state_d),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // a byte with no result never waits on the output side
  assign fire       = in_vld_q && (!res_vld || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire && res_vld) out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= StateClear;
      thresh_q  <= ThreshReset;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      out_vld_q <= out_vld_d;
      if (fire) state_q <= state_d;
      if (psel && penable && pwrite && pready && paddr == AddrConfirmThreshold) begin
        thresh_q <= pwdata[3:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_item_i;
    if (fire && res_vld) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr == AddrConfirmThreshold) ? {28'd0, thresh_q} : 32'd0;

endmodule
